>>> src/mctb_pkg.sv
// Shared types, codes and sizes for the tick timer bank.
package mctb_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int MAX_RESULTS = 8;
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int NEV_W = $clog2(MAX_RESULTS + 1);
	localparam int CMDQ_DEPTH = 2;
	localparam int OUTQ_DEPTH = 2;
	localparam logic [15:0] ENDLESS_RESET = 16'hFFFF;

	localparam logic [2:0] ACT_TICK = 3'd0;
	localparam logic [2:0] ACT_REGISTER = 3'd1;
	localparam logic [2:0] ACT_START = 3'd2;
	localparam logic [2:0] ACT_STOP = 3'd3;
	localparam logic [2:0] ACT_QUERY = 3'd4;

	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_REGISTER,
		OP_START,
		OP_STOP,
		OP_QUERY
	} op_t;

	typedef struct packed {
		logic [2:0] action;
		logic [5:0] timer_id;
		logic periodic;
		logic has_callback;
		logic [15:0] length;
	} in_item_t;

	typedef struct packed {
		logic kind;
		logic [5:0] timer_id_res;
		logic timed_out;
		logic last;
	} out_item_t;

	typedef struct packed {
		op_t op;
		logic id_ok;
		logic [5:0] id;
		logic periodic;
		logic has_callback;
		logic [15:0] length;
	} cmd_t;

endpackage

>>> src/multi_channel_tick_timer_bank_unit.sv
// Top level of the tick timer bank: front end, command queue and timer engine.
//
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------
// command  | push / full        | cmd (in_item_t)
// result   | pop / empty        | rsp (out_item_t)
// config   | cfg_valid/cfg_ready| cfg_data (endless count)
//
// Register, start, stop and query are each executed in the engine's idle state.
// A tick scans one timer per cycle while the result queue is not full, then passes through ST_DONE.
// Reset clears every timer and sets the endless count to all ones.
// Queries and the tick scan stall while the two-entry result queue is full; the front end
// keeps accepting until its stage register and the command queue are full.
module multi_channel_tick_timer_bank_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  mctb_pkg::in_item_t cmd,
	output logic empty,
	input  logic pop,
	output mctb_pkg::out_item_t rsp,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data
);
	import mctb_pkg::*;

	cmd_t fq_cmd;
	logic fq_push;
	logic fq_full;
	cmd_t qb_cmd;
	logic qb_empty;
	logic qb_pop;

	mctb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.cmd    (cmd),
		.q_push (fq_push),
		.q_cmd  (fq_cmd),
		.q_full (fq_full)
	);

	mctb_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data (fq_cmd),
		.full    (fq_full),
		.rd_en   (qb_pop),
		.rd_data (qb_cmd),
		.empty   (qb_empty)
	);

	mctb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_data    (qb_cmd),
		.q_empty   (qb_empty),
		.q_pop     (qb_pop),
		.rsp       (rsp),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

>>> src/mctb_front.sv
// Front end: takes input transfers, decodes the action and drops ignored commands.
module mctb_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  mctb_pkg::in_item_t cmd,
	output logic q_push,
	output mctb_pkg::cmd_t q_cmd,
	input  logic q_full
);
	import mctb_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t dec;
	logic keep;
	logic id_ok;

	assign id_ok = {1'b0, cmd.timer_id} < 7'(NUM_TIMERS);

	always_comb begin
		dec.op = OP_TICK;
		dec.id_ok = id_ok;
		dec.id = cmd.timer_id;
		dec.periodic = cmd.periodic;
		dec.has_callback = cmd.has_callback;
		dec.length = cmd.length;
		keep = 1'b0;
		case (cmd.action)
			ACT_TICK: begin
				dec.op = OP_TICK;
				keep = 1'b1;
			end
			ACT_REGISTER: begin
				dec.op = OP_REGISTER;
				keep = id_ok;
			end
			ACT_START: begin
				dec.op = OP_START;
				keep = id_ok;
			end
			ACT_STOP: begin
				dec.op = OP_STOP;
				keep = id_ok;
			end
			ACT_QUERY: begin
				dec.op = OP_QUERY;
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full = valid_s1 & q_full;
	assign q_push = valid_s1 & ~q_full;
	assign q_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push & keep;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			cmd_s1 <= dec;
		end
	end

endmodule

>>> src/mctb_cmdq.sv
// Short command queue between the front end and the timer engine.
module mctb_cmdq (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  mctb_pkg::cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output mctb_pkg::cmd_t rd_data,
	output logic empty
);
	import mctb_pkg::*;

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t mem_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign full = cnt_q == CNT_W'(CMDQ_DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr_en & ~full;
	assign do_rd = rd_en & ~empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

>>> src/mctb_back.sv
// Timer engine: timer state, command execution, tick scan and result queue.
module mctb_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data,
	input  mctb_pkg::cmd_t q_data,
	input  logic q_empty,
	output logic q_pop,
	output mctb_pkg::out_item_t rsp,
	output logic empty,
	input  logic pop
);
	import mctb_pkg::*;

	localparam int OQ_PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
	localparam int OQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	typedef struct packed {
		logic run;
		logic expd;
		logic per;
		logic rep;
		logic [15:0] cnt;
		logic [15:0] il;
		logic [15:0] rl;
	} timer_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] idx_q;
	logic [NEV_W-1:0] nev_q;
	logic pend_v_q;
	logic [5:0] pend_id_q;
	logic [15:0] endless_q;
	timer_t tmr_q [NUM_TIMERS];

	out_item_t oq_mem_q [OUTQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wp_q;
	logic [OQ_PTR_W-1:0] oq_rp_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;
	logic oq_full;
	logic oq_push;
	logic oq_pop;
	out_item_t oq_din;

	logic [IDX_W-1:0] rd_idx;
	timer_t cur;
	timer_t tick_nxt;
	timer_t wr_ent;
	logic wr_en;
	logic fire;
	logic ev;
	logic [15:0] cnt_dec;
	logic [15:0] il_dec;
	logic cnt_zero;
	logic il_zero;
	logic scan_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			endless_q <= ENDLESS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			endless_q <= cfg_data;
		end
	end

	assign rd_idx = (state_q == ST_SCAN) ? idx_q : q_data.id[IDX_W-1:0];
	assign cur = tmr_q[rd_idx];
	assign scan_last = idx_q == IDX_W'(NUM_TIMERS - 1);

	always_comb begin
		tick_nxt = cur;
		fire = 1'b0;
		cnt_dec = (cur.cnt != endless_q) ? cur.cnt - 16'd1 : cur.cnt;
		cnt_zero = cnt_dec == '0;
		il_dec = cur.il - 16'd1;
		il_zero = il_dec == '0;
		if (cur.run && !cur.expd) begin
			tick_nxt.cnt = cnt_dec;
			if (cnt_zero) begin
				tick_nxt.expd = 1'b1;
				fire = cur.rep & ~cur.per;
			end
			if (cur.per) begin
				tick_nxt.il = il_zero ? cur.rl : il_dec;
				fire = fire | (il_zero & cur.rep);
			end
		end
	end

	assign ev = fire && (nev_q < NEV_W'(MAX_RESULTS));

	always_comb begin
		wr_en = 1'b0;
		wr_ent = cur;
		oq_push = 1'b0;
		oq_din = '0;
		q_pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					case (q_data.op)
						OP_TICK: begin
							q_pop = 1'b1;
						end
						OP_REGISTER: begin
							q_pop = 1'b1;
							wr_en = 1'b1;
							wr_ent.per = q_data.periodic;
							wr_ent.rep = q_data.has_callback;
							if (q_data.periodic) begin
								wr_ent.rl = q_data.length;
								wr_ent.il = q_data.length;
							end
						end
						OP_START: begin
							q_pop = 1'b1;
							wr_en = 1'b1;
							wr_ent.cnt = q_data.length;
							wr_ent.expd = 1'b0;
							wr_ent.run = 1'b1;
						end
						OP_STOP: begin
							q_pop = 1'b1;
							wr_en = 1'b1;
							wr_ent = '0;
						end
						OP_QUERY: begin
							if (!oq_full) begin
								q_pop = 1'b1;
								oq_push = 1'b1;
								oq_din.kind = KIND_QUERY;
								oq_din.timer_id_res = q_data.id;
								oq_din.timed_out = q_data.id_ok & cur.expd;
								oq_din.last = 1'b1;
							end
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (!oq_full) begin
					wr_en = 1'b1;
					wr_ent = tick_nxt;
					if (ev && pend_v_q) begin
						oq_push = 1'b1;
						oq_din.kind = KIND_EVENT;
						oq_din.timer_id_res = pend_id_q;
						oq_din.last = 1'b0;
					end
				end
			end
			ST_DONE: begin
				if (pend_v_q && !oq_full) begin
					oq_push = 1'b1;
					oq_din.kind = KIND_EVENT;
					oq_din.timer_id_res = pend_id_q;
					oq_din.last = 1'b1;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			nev_q <= '0;
			pend_v_q <= 1'b0;
			pend_id_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty && q_data.op == OP_TICK) begin
						state_q <= ST_SCAN;
						idx_q <= '0;
						nev_q <= '0;
						pend_v_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (!oq_full) begin
						if (ev) begin
							pend_v_q <= 1'b1;
							pend_id_q <= 6'(idx_q);
							nev_q <= nev_q + 1'b1;
						end
						if (scan_last) begin
							state_q <= ST_DONE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (!pend_v_q || !oq_full) begin
						state_q <= ST_IDLE;
						pend_v_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				tmr_q[i] <= '0;
			end
		end else if (wr_en) begin
			tmr_q[rd_idx] <= wr_ent;
		end
	end

	assign oq_full = oq_cnt_q == OQ_CNT_W'(OUTQ_DEPTH);
	assign empty = oq_cnt_q == '0;
	assign oq_pop = pop & ~empty;
	assign rsp = oq_mem_q[oq_rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q <= '0;
			oq_rp_q <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wp_q <= (oq_wp_q == OQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_wp_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rp_q <= (oq_rp_q == OQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_rp_q + 1'b1;
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (oq_pop && !oq_push) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_mem_q[oq_wp_q] <= oq_din;
		end
	end

endmodule

>>> src/mctb_checker.sv
// Port-level checks for the tick timer bank and their binding to the top level.
module mctb_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input mctb_pkg::out_item_t rsp
);
	import mctb_pkg::*;

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("Waiting result vanished without a transfer.");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(rsp))
		else $error("Waiting result changed without a transfer.");

	a_query_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.kind == KIND_QUERY |-> rsp.last)
		else $error("Query reply without last flag.");

	a_event_no_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.kind == KIND_EVENT |-> !rsp.timed_out)
		else $error("Fire event carries a timed-out flag.");

	a_event_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.kind == KIND_EVENT |-> {1'b0, rsp.timer_id_res} < 7'(NUM_TIMERS))
		else $error("Fire event for a timer that does not exist.");

endmodule

bind multi_channel_tick_timer_bank_unit mctb_checker u_mctb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.rsp    (rsp)
);

>>> dv/tb.sv
// Self-checking testbench for the tick timer bank: directed table, then random commands.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mctb_pkg::*;

	localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 64;
	localparam int SEG_COUNT = 6;
	localparam int SEG_ITEMS = 80;
	localparam int MAX_PRINTED = 40;

	typedef struct {
		in_item_t item;
		bit typed;
		out_item_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_item_t cmd;
	logic empty;
	logic pop;
	out_item_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;

	bit tmr_run [NUM_TIMERS];
	bit tmr_expired [NUM_TIMERS];
	bit tmr_periodic [NUM_TIMERS];
	bit tmr_report [NUM_TIMERS];
	bit [15:0] tmr_count [NUM_TIMERS];
	bit [15:0] tmr_interval [NUM_TIMERS];
	bit [15:0] tmr_reload [NUM_TIMERS];
	bit [15:0] endless_val;

	out_item_t rsp_due[$];
	plan_row_t plan[$];
	int err_count = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	multi_channel_tick_timer_bank_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_slot(input int t);
		tmr_run[t] = 1'b0;
		tmr_expired[t] = 1'b0;
		tmr_periodic[t] = 1'b0;
		tmr_report[t] = 1'b0;
		tmr_count[t] = '0;
		tmr_interval[t] = '0;
		tmr_reload[t] = '0;
	endfunction

	// Applies one command to the timer state and queues the results it causes.
	function automatic void step_timers(input in_item_t c);
		out_item_t r;
		bit hit;
		bit id_ok;
		int id;
		int n;
		id = c.timer_id;
		id_ok = id < NUM_TIMERS;
		n = 0;
		r = '0;
		case (c.action)
		ACT_TICK: begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				hit = 1'b0;
				if (tmr_run[t] && !tmr_expired[t]) begin
					if (tmr_count[t] != endless_val)
						tmr_count[t] = tmr_count[t] - 16'd1;
					if (tmr_count[t] == 16'd0) begin
						tmr_expired[t] = 1'b1;
						if (tmr_report[t] && !tmr_periodic[t])
							hit = 1'b1;
					end
					if (tmr_periodic[t]) begin
						tmr_interval[t] = tmr_interval[t] - 16'd1;
						if (tmr_interval[t] == 16'd0) begin
							if (tmr_report[t])
								hit = 1'b1;
							tmr_interval[t] = tmr_reload[t];
						end
					end
					if (hit && n < MAX_RESULTS) begin
						r.kind = KIND_EVENT;
						r.timer_id_res = 6'(t);
						r.timed_out = 1'b0;
						r.last = 1'b0;
						rsp_due.push_back(r);
						n++;
					end
				end
			end
		end
		ACT_REGISTER: begin
			if (id_ok) begin
				tmr_periodic[id] = c.periodic;
				if (c.periodic) begin
					tmr_reload[id] = c.length;
					tmr_interval[id] = c.length;
				end
				tmr_report[id] = c.has_callback;
			end
		end
		ACT_START: begin
			if (id_ok) begin
				tmr_count[id] = c.length;
				tmr_expired[id] = 1'b0;
				tmr_run[id] = 1'b1;
			end
		end
		ACT_STOP: begin
			if (id_ok)
				clear_slot(id);
		end
		ACT_QUERY: begin
			r.kind = KIND_QUERY;
			r.timer_id_res = c.timer_id;
			r.timed_out = 1'b0;
			if (id_ok)
				r.timed_out = tmr_expired[id];
			r.last = 1'b0;
			rsp_due.push_back(r);
			n = 1;
		end
		default: begin
		end
		endcase
		if (n > 0) begin
			r = rsp_due.pop_back();
			r.last = 1'b1;
			rsp_due.push_back(r);
		end
	endfunction

	function automatic plan_row_t cmd_row(input logic [2:0] a, input int id, input bit per,
		input bit cb, input logic [15:0] len);
		plan_row_t row;
		row.item.action = a;
		row.item.timer_id = 6'(id);
		row.item.periodic = per;
		row.item.has_callback = cb;
		row.item.length = len;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic plan_row_t query_row(input int id, input bit to);
		plan_row_t row;
		row = cmd_row(ACT_QUERY, id, 1'b0, 1'b0, 16'h0000);
		row.typed = 1'b1;
		row.want.kind = KIND_QUERY;
		row.want.timer_id_res = 6'(id);
		row.want.timed_out = to;
		row.want.last = 1'b1;
		return row;
	endfunction

	function automatic logic [5:0] pick_id();
		if ($urandom_range(99) < 88)
			return 6'($urandom_range(NUM_TIMERS - 1));
		return 6'($urandom_range(63));
	endfunction

	function automatic in_item_t random_command();
		in_item_t c;
		int r;
		int sel;
		c.timer_id = pick_id();
		c.periodic = 1'($urandom_range(1));
		c.has_callback = 1'($urandom_range(1));
		c.length = 16'($urandom);
		r = $urandom_range(99);
		sel = $urandom_range(19);
		if (r < 45) begin
			c.action = ACT_TICK;
			c.timer_id = 6'($urandom_range(63));
		end else if (r < 58) begin
			c.action = ACT_REGISTER;
			c.has_callback = ($urandom_range(9) != 0);
			if (sel < 2)
				c.length = 16'h0000;
			else if (sel < 4)
				c.length = 16'($urandom);
			else
				c.length = 16'($urandom_range(1, 6));
		end else if (r < 73) begin
			c.action = ACT_START;
			if (sel < 3)
				c.length = 16'h0000;
			else if (sel == 3)
				c.length = endless_val;
			else if (sel == 4)
				c.length = endless_val + 16'd1;
			else if (sel < 7)
				c.length = 16'($urandom);
			else
				c.length = 16'($urandom_range(1, 12));
		end else if (r < 80) begin
			c.action = ACT_STOP;
		end else if (r < 95) begin
			c.action = ACT_QUERY;
		end else begin
			c.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
			c.timer_id = 6'($urandom_range(63));
		end
		return c;
	endfunction

	function automatic string show(input out_item_t r);
		return $sformatf("kind=%0d id=%0d timed_out=%0d last=%0d",
			r.kind, r.timer_id_res, r.timed_out, r.last);
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_PRINTED)
			$display("tb: mismatch at cycle %0d: %s", cycles, msg);
		err_count++;
	endtask

	task automatic send_cmd(input in_item_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		cmd <= c;
		push <= 1'b1;
		@(posedge clk);
		while (full !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_endless(input logic [15:0] v);
		push <= 1'b0;
		@(posedge clk);
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		cfg_valid <= 1'b0;
		endless_val = v;
	endtask

	always @(posedge clk) begin : rsp_check
		out_item_t want;
		if (arst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
			if (rsp_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing due: %s", show(rsp)));
			end else begin
				want = rsp_due.pop_front();
				if (rsp.kind !== want.kind || rsp.timer_id_res !== want.timer_id_res
					|| rsp.timed_out !== want.timed_out || rsp.last !== want.last)
					report_mismatch($sformatf("got %s, want %s", show(rsp), show(want)));
			end
		end
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		in_item_t c;
		out_item_t r;
		int due_count;
		int done;
		logic [15:0] setting;
		push <= 1'b0;
		cmd <= '0;
		pop <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		send_idle_pct = 33;
		recv_idle_pct = 48;
		endless_val = ENDLESS_RESET;
		for (int t = 0; t < NUM_TIMERS; t++)
			clear_slot(t);

		plan.push_back(query_row(0, 1'b0));
		plan.push_back(query_row(63, 1'b0));
		plan.push_back(cmd_row(ACT_REGISTER, 0, 1'b0, 1'b1, 16'hFFFF));
		plan.push_back(cmd_row(ACT_START, 0, 1'b0, 1'b0, 16'h0001));
		plan.push_back(cmd_row(ACT_TICK, 0, 1'b0, 1'b0, 16'h0000));
		plan.push_back(query_row(0, 1'b1));
		plan.push_back(cmd_row(ACT_REGISTER, 7, 1'b1, 1'b1, 16'h0002));
		plan.push_back(cmd_row(ACT_START, 7, 1'b0, 1'b0, 16'h0000));
		plan.push_back(cmd_row(ACT_TICK, 0, 1'b0, 1'b0, 16'h0000));
		plan.push_back(cmd_row(ACT_TICK, 0, 1'b0, 1'b0, 16'h0000));
		plan.push_back(cmd_row(ACT_REGISTER, 1, 1'b1, 1'b1, 16'h0000));
		plan.push_back(cmd_row(ACT_START, 1, 1'b0, 1'b0, 16'h0003));
		plan.push_back(cmd_row(ACT_REGISTER, 63, 1'b1, 1'b1, 16'hFFFF));
		plan.push_back(cmd_row(ACT_START, NUM_TIMERS, 1'b0, 1'b0, 16'h0005));
		plan.push_back(cmd_row(ACT_STOP, 40, 1'b0, 1'b0, 16'h0000));
		plan.push_back(cmd_row(ACT_UNUSED_LO, 0, 1'b0, 1'b0, 16'h0000));
		plan.push_back(cmd_row(ACT_UNUSED_HI, 63, 1'b1, 1'b1, 16'hFFFF));
		plan.push_back(cmd_row(ACT_TICK, 63, 1'b1, 1'b1, 16'hFFFF));
		plan.push_back(cmd_row(ACT_TICK, 0, 1'b0, 1'b0, 16'h0000));
		plan.push_back(cmd_row(ACT_TICK, 0, 1'b0, 1'b0, 16'h0000));
		plan.push_back(query_row(1, 1'b1));
		plan.push_back(cmd_row(ACT_STOP, 7, 1'b0, 1'b0, 16'h0000));
		plan.push_back(query_row(7, 1'b0));
		plan.push_back(cmd_row(ACT_START, 2, 1'b0, 1'b0, 16'hFFFF));
		plan.push_back(cmd_row(ACT_TICK, 0, 1'b0, 1'b0, 16'h0000));
		plan.push_back(query_row(2, 1'b0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			send_cmd(plan[i].item);
			due_count = rsp_due.size();
			step_timers(plan[i].item);
			if (plan[i].typed) begin
				while (rsp_due.size() > due_count)
					r = rsp_due.pop_back();
				rsp_due.push_back(plan[i].want);
			end
		end

		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			case (seg)
			0: setting = 16'hFFFF;
			1: setting = 16'h0000;
			2: setting = 16'h0005;
			3: setting = 16'($urandom);
			4: setting = 16'h0001;
			default: setting = 16'hFFFE;
			endcase
			write_endless(setting);
			send_idle_pct = (seg < 2) ? 33 : (seg < 4) ? 48 : 0;
			recv_idle_pct = (seg < 2) ? 48 : (seg < 4) ? 33 : 0;
			done = 0;
			while (done < SEG_ITEMS) begin
				if (seg == 1 && done == SEG_ITEMS / 2) begin
					push <= 1'b0;
					@(posedge clk);
					while (rsp_due.size() != 0)
						@(posedge clk);
				end
				c = random_command();
				send_cmd(c);
				step_timers(c);
				// Commands the block drops do not count toward the segment.
				if (c.action == ACT_TICK || c.action == ACT_QUERY
					|| (c.action <= ACT_STOP && c.timer_id < NUM_TIMERS))
					done++;
			end
		end

		push <= 1'b0;
		@(posedge clk);
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

>>> multi_channel_tick_timer_bank_unit.f
src/mctb_pkg.sv
src/mctb_front.sv
src/mctb_cmdq.sv
src/mctb_back.sv
src/multi_channel_tick_timer_bank_unit.sv
src/mctb_checker.sv
dv/tb.sv
